### hdl/sitda_pkg.sv
// sitda_pkg: shared types, constants and the double-dabble step for the
// signed integer to decimal ascii converter; depends on nothing
package sitda_pkg;

   localparam int VALUE_W        = 32;
   localparam int DIGITS         = 10;
   localparam int BCD_W          = 4 * DIGITS;
   localparam int IDX_W          = 4;
   localparam int CHAR_W         = 6;
   localparam int BITS_PER_STAGE = 4;
   localparam int DABBLE_STAGES  = VALUE_W / BITS_PER_STAGE;

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0] ASCII_NINE  = 6'd57;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

   // payload carried down the conversion pipeline
   typedef struct packed {
      logic               neg;
      logic [VALUE_W-1:0] mag;
      logic [BCD_W-1:0]   bcd;
   } stage_type;

   // one shift-add-3 step: adjust every digit, then shift in the next bit
   function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                    input logic bit_in);
      logic [BCD_W-1:0] adj;
      adj = bcd;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
         end
      end
      return {adj[BCD_W-2:0], bit_in};
   endfunction

endpackage

### hdl/sitda_dabble_stage.sv
// sitda_dabble_stage: one register stage of the binary to bcd pipeline,
// shifts BITS_PER_STAGE magnitude bits into the bcd word; uses sitda_pkg
module sitda_dabble_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  sitda_pkg::stage_type in_data,
   output logic                 out_valid,
   output sitda_pkg::stage_type out_data
);

   logic                 valid_ff;
   sitda_pkg::stage_type data_ff;
   sitda_pkg::stage_type data_in;

   always_comb begin
      data_in = in_data;
      for (int s = 0; s < sitda_pkg::BITS_PER_STAGE; s++) begin
         data_in.bcd = sitda_pkg::dabble_step(data_in.bcd,
                                              data_in.mag[sitda_pkg::VALUE_W-1]);
         data_in.mag = {data_in.mag[sitda_pkg::VALUE_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### hdl/signed_int_to_decimal_ascii_top.sv
// signed_int_to_decimal_ascii_top: top level of the integer to ascii converter
// depends on sitda_pkg and sitda_dabble_stage
//
// Converts one 32-bit two's complement integer per request into its decimal
// ascii text, one character per cycle on rsp_character with rsp_valid as the
// strobe, most significant first, a leading '-' for negative values, no
// leading zeros, and rsp_last on the final character. A request is taken at a
// rising edge where start is high and busy is low. The result port cannot be
// stalled: each character is shown for exactly one cycle. A request yields 1
// to 11 characters and holds the character serializer while they are printed,
// so that serializer sets the sustained rate, depending on the number's length.
// In front of it sits a nine-stage pipeline (magnitude register plus eight
// double-dabble stages of four bits each) that accepts a request every cycle
// while it has room, so up to nine requests can be queued behind the one being
// printed. A request taken into an empty pipeline passes through the magnitude
// register, the eight dabble stages, the serializer and the output register.
module signed_int_to_decimal_ascii_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [sitda_pkg::VALUE_W-1:0] req_value,
   output logic                                 rsp_valid,
   output logic [sitda_pkg::CHAR_W-1:0]         rsp_character,
   output logic                                 rsp_last
);

   localparam int NS = sitda_pkg::DABBLE_STAGES;

   // front stage: sign and magnitude
   logic                 front_valid_ff;
   sitda_pkg::stage_type front_data_ff;
   logic                 front_en;
   logic                 accept;
   logic [sitda_pkg::VALUE_W-1:0] value_bits;

   // dabble pipeline
   logic                 stage_valid [NS];
   sitda_pkg::stage_type stage_data  [NS];
   logic                 stage_en    [NS];

   // serializer
   logic                          ser_valid_ff, ser_valid_in;
   logic                          ser_sign_ff, ser_sign_in;
   logic [sitda_pkg::IDX_W-1:0]   ser_idx_ff, ser_idx_in;
   logic [sitda_pkg::BCD_W-1:0]   ser_bcd_ff, ser_bcd_in;
   logic                          ser_free;
   logic                          ser_load;
   logic [sitda_pkg::IDX_W-1:0]   load_idx;
   logic [3:0]                    cur_digit;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sitda_pkg::CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic                          rsp_last_ff, rsp_last_in;

   // serializer takes a new number when empty or on its final character
   assign ser_free = !ser_valid_ff || (!ser_sign_ff && (ser_idx_ff == '0));
   assign ser_load = stage_valid[NS-1] && ser_free;

   // backpressure chain: a stage moves when it is empty or its successor moves
   always_comb begin
      stage_en[NS-1] = !stage_valid[NS-1] || ser_free;
      for (int i = NS - 2; i >= 0; i--) begin
         stage_en[i] = !stage_valid[i] || stage_en[i+1];
      end
   end

   assign front_en = !front_valid_ff || stage_en[0];
   assign busy     = !front_en;
   assign accept   = start && !busy;

   // magnitude in 32 unsigned bits, so the most negative value still works
   assign value_bits = req_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (front_en) begin
         front_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         front_data_ff.neg <= value_bits[sitda_pkg::VALUE_W-1];
         front_data_ff.mag <= value_bits[sitda_pkg::VALUE_W-1] ? (~value_bits + 1'b1)
                                                                : value_bits;
         front_data_ff.bcd <= '0;
      end
   end

   // eight stages of four double-dabble steps each
   for (genvar g = 0; g < NS; g++) begin : g_dabble
      if (g == 0) begin : g_first
         sitda_dabble_stage u_stage (
            .clock     (clock),
            .reset     (reset),
            .advance   (stage_en[g]),
            .in_valid  (front_valid_ff),
            .in_data   (front_data_ff),
            .out_valid (stage_valid[g]),
            .out_data  (stage_data[g])
         );
      end else begin : g_rest
         sitda_dabble_stage u_stage (
            .clock     (clock),
            .reset     (reset),
            .advance   (stage_en[g]),
            .in_valid  (stage_valid[g-1]),
            .in_data   (stage_data[g-1]),
            .out_valid (stage_valid[g]),
            .out_data  (stage_data[g])
         );
      end
   end

   // most significant nonzero digit; zero prints as a single '0'
   always_comb begin
      load_idx = '0;
      for (int i = 0; i < sitda_pkg::DIGITS; i++) begin
         if (stage_data[NS-1].bcd[4*i +: 4] != 4'd0) begin
            load_idx = sitda_pkg::IDX_W'(i);
         end
      end
   end

   assign cur_digit = ser_bcd_ff[ser_idx_ff*4 +: 4];

   // emit one character per cycle, then step the digit pointer down
   always_comb begin
      ser_valid_in = ser_valid_ff;
      ser_sign_in  = ser_sign_ff;
      ser_idx_in   = ser_idx_ff;
      ser_bcd_in   = ser_bcd_ff;
      rsp_valid_in = ser_valid_ff;
      rsp_char_in  = sitda_pkg::ASCII_ZERO + {2'b00, cur_digit};
      rsp_last_in  = 1'b0;

      if (ser_valid_ff) begin
         if (ser_sign_ff) begin
            rsp_char_in = sitda_pkg::ASCII_MINUS;
            ser_sign_in = 1'b0;
         end else if (ser_idx_ff == '0) begin
            rsp_last_in  = 1'b1;
            ser_valid_in = 1'b0;
         end else begin
            ser_idx_in = ser_idx_ff - 1'b1;
         end
      end

      if (ser_load) begin
         ser_valid_in = 1'b1;
         ser_sign_in  = stage_data[NS-1].neg;
         ser_idx_in   = load_idx;
         ser_bcd_in   = stage_data[NS-1].bcd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
         ser_sign_ff  <= 1'b0;
         ser_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ser_valid_ff <= ser_valid_in;
         ser_sign_ff  <= ser_sign_in;
         ser_idx_ff   <= ser_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ser_bcd_ff  <= ser_bcd_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTHESIS
   // a strobed character is always '-' or a digit
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character == sitda_pkg::ASCII_MINUS) ||
                    ((rsp_character >= sitda_pkg::ASCII_ZERO) &&
                     (rsp_character <= sitda_pkg::ASCII_NINE)))
      else $error("character out of range");

   // the sign is never the final character
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_character == sitda_pkg::ASCII_MINUS)) |-> !rsp_last)
      else $error("minus sign marked last");

   // a number's characters come out in consecutive cycles
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("gap inside a number");

   // the block is never busy with an empty front stage
   a_busy_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !front_valid_ff |-> !busy)
      else $error("busy with empty front stage");
`endif

endmodule
